### design/lru_key_value_cache_top_defines.svh
// Assertion macros used by the checker file.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define LKVC_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define LKVC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define LKVC_ASSERT_AFTER_RESET(name, clk, rst, cons, msg) \
   name: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

### design/lkvc_pkg.sv
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int KEY_WIDTH       = 32;
   localparam int VALUE_WIDTH     = 32;
   localparam int CAP_WIDTH       = 5;

   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } lkvc_op_type;

   // One word handed from the input register to the table.
   typedef struct packed {
      logic                   fire;
      logic                   op;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } lkvc_cmd_type;

   typedef struct packed {
      logic                   hit;
      logic [VALUE_WIDTH-1:0] read_value;
   } lkvc_result_type;

endpackage

### design/lkvc_req_if.sv
interface lkvc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [lkvc_pkg::KEY_WIDTH-1:0]   key;
   logic [lkvc_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink   (input valid, input op, input key, input value, output ready);
endinterface

### design/lkvc_rsp_if.sv
interface lkvc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [lkvc_pkg::VALUE_WIDTH-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

### design/lkvc_table.sv
module lkvc_table #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0]   capacity,
   input  lkvc_pkg::lkvc_cmd_type           cmd,
   output lkvc_pkg::lkvc_result_type        result
);

   localparam int RW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   logic [lkvc_pkg::KEY_WIDTH-1:0]   keys_ff   [ENTRIES];
   logic [lkvc_pkg::VALUE_WIDTH-1:0] values_ff [ENTRIES];
   logic [ENTRIES-1:0]               valid_ff;
   logic [ENTRIES-1:0]               valid_in;
   logic [RW-1:0]                    rank_ff   [ENTRIES];
   logic [RW-1:0]                    rank_in   [ENTRIES];
   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    count_in;

   logic [ENTRIES-1:0]               match;
   logic                             hit_any;
   logic [RW-1:0]                    hit_idx;
   logic [RW-1:0]                    hit_rank;
   logic [lkvc_pkg::VALUE_WIDTH-1:0] hit_data;
   logic [RW-1:0]                    lru_idx;
   logic [CW-1:0]                    last_rank;
   logic [CW-1:0]                    eff_cap;
   logic                             full;
   logic                             is_put;
   logic                             update;
   logic                             insert_new;
   logic [RW-1:0]                    tgt;
   logic [CW-1:0]                    thresh;

   always_comb begin
      if (capacity == '0) begin
         eff_cap = CW'(1);
      end else if (32'(capacity) > 32'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = CW'(capacity);
      end
   end

   assign last_rank = count_ff - CW'(1);
   assign full      = (count_ff >= eff_cap);

   // Keys of valid entries are unique and ranks form a permutation, so at most
   // one lane matches and at most one lane holds the oldest rank: OR them together.
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      hit_data = '0;
      lru_idx  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (keys_ff[i] == cmd.key);
         if (match[i]) begin
            hit_idx  = hit_idx | RW'(i);
            hit_rank = hit_rank | rank_ff[i];
            hit_data = hit_data | values_ff[i];
         end
         if (valid_ff[i] && (CW'(rank_ff[i]) == last_rank)) begin
            lru_idx = lru_idx | RW'(i);
         end
      end
   end

   assign hit_any    = |match;
   assign is_put     = (cmd.op == lkvc_pkg::OP_PUT);
   assign update     = cmd.fire && (hit_any || is_put);
   assign insert_new = cmd.fire && is_put && !hit_any && !full;

   // Valid slots always fill from the bottom, so the first free slot is the count.
   always_comb begin
      if (hit_any) begin
         tgt    = hit_idx;
         thresh = CW'(hit_rank);
      end else if (full) begin
         tgt    = lru_idx;
         thresh = last_rank;
      end else begin
         tgt    = RW'(count_ff);
         thresh = count_ff;
      end
   end

   // Age every valid entry more recent than the target; target becomes newest.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i]  = rank_ff[i];
         valid_in[i] = valid_ff[i];
         if (update) begin
            if (RW'(i) == tgt) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (CW'(rank_ff[i]) < thresh)) begin
               rank_in[i] = rank_ff[i] + RW'(1);
            end
         end
         if (insert_new && (RW'(i) == tgt)) begin
            valid_in[i] = 1'b1;
         end
      end
   end

   assign count_in = count_ff + CW'(insert_new);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire && is_put) begin
         keys_ff[tgt]   <= cmd.key;
         values_ff[tgt] <= cmd.value;
      end
   end

   assign result.hit        = hit_any;
   assign result.read_value = hit_data;

endmodule

### design/lru_key_value_cache_top.sv
// Channel | Dir | Word                      | Notes
// req     | in  | op, key, value            | get or put
// rsp     | out | hit, read_value           | one word per get, none per put
// csr     | in  | capacity (5 bits)         | write enable, no read-back
//
// One word is accepted per cycle while req.ready is high; a get's word passes
// the input register and then the result register before it is valid on rsp.
// The whole lookup, replacement choice and recency update are worked out
// combinationally in lkvc_table, between the input register and the result register.
// Reset is synchronous, active high: table empty, capacity back to 16.
// A held result stalls only a waiting get; puts keep flowing under rsp stall.
module lru_key_value_cache_top #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   lkvc_req_if.sink                       req,
   lkvc_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [lkvc_pkg::CAP_WIDTH-1:0] csr_write_data
);

   logic [lkvc_pkg::CAP_WIDTH-1:0]   capacity_ff;
   logic                             stage_valid_ff;
   logic                             stage_valid_in;
   logic                             stage_op_ff;
   logic [lkvc_pkg::KEY_WIDTH-1:0]   stage_key_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0] stage_value_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             rsp_hit_ff;
   logic [lkvc_pkg::VALUE_WIDTH-1:0] rsp_read_value_ff;
   logic                             advance;
   logic                             accept;
   lkvc_pkg::lkvc_cmd_type           cmd;
   lkvc_pkg::lkvc_result_type        result;

   // A put never needs the result slot; a get needs it empty or draining.
   assign advance = stage_valid_ff &&
                    ((stage_op_ff == lkvc_pkg::OP_PUT) || !rsp_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && (stage_op_ff == lkvc_pkg::OP_GET)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cmd.fire  = advance;
   assign cmd.op    = stage_op_ff;
   assign cmd.key   = stage_key_ff;
   assign cmd.value = stage_value_ff;

   lkvc_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity_ff),
      .cmd      (cmd),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= lkvc_pkg::CAPACITY_RESET;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_op_ff    <= req.op;
         stage_key_ff   <= req.key;
         stage_value_ff <= req.value;
      end
      // Load the result only when a get leaves the input register.
      if (advance && (stage_op_ff == lkvc_pkg::OP_GET)) begin
         rsp_hit_ff        <= result.hit;
         rsp_read_value_ff <= result.read_value;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.read_value = rsp_read_value_ff;

endmodule

### design/lkvc_checker.sv
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_hit,
   input logic [lkvc_pkg::VALUE_WIDTH-1:0] rsp_read_value
);

   `LKVC_ASSERT_AFTER_RESET(a_rsp_idle_after_reset, clock, reset, !rsp_valid, "rsp valid after reset")

   `LKVC_ASSERT_IMPLY(a_miss_reads_zero, clock, reset, rsp_valid && !rsp_hit, rsp_read_value == '0, "miss with nonzero value")

   `LKVC_ASSERT_IMPLY(a_ready_when_rsp_empty, clock, reset, !rsp_valid, req_ready, "req stalled with empty result slot")

   `LKVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value), "stalled rsp word changed")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_hit        (rsp.hit),
   .rsp_read_value (rsp.read_value)
);

### tb/sv/lru_key_value_cache_top_test.sv
module lru_key_value_cache_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES     = lkvc_pkg::ENTRIES_DEFAULT;
   localparam int KW          = lkvc_pkg::KEY_WIDTH;
   localparam int VW          = lkvc_pkg::VALUE_WIDTH;
   localparam int CPW         = lkvc_pkg::CAP_WIDTH;
   localparam int KEY_POOL    = 24;
   localparam int SEGMENTS    = 8;
   localparam int SEG_WORDS   = 150;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum {ROW_WORD, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      lkvc_pkg::lkvc_op_type op;
      logic [KW-1:0]         key;
      logic [VW-1:0]         value;
      bit                    typed;
      logic                  exp_hit;
      logic [VW-1:0]         exp_value;
   } cache_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CPW-1:0] csr_write_data;

   lkvc_req_if req_if();
   lkvc_rsp_if rsp_if();

   lru_key_value_cache_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the cache contents and recency order
   logic [KW-1:0]          slot_key [ENTRIES];
   logic [VW-1:0]          slot_val [ENTRIES];
   bit                     slot_used[ENTRIES];
   int unsigned            slot_age [ENTRIES];
   int unsigned            used_count;
   logic [CPW-1:0]         cap_reg;

   lkvc_pkg::lkvc_result_type pending_reads[$];
   lkvc_pkg::lkvc_result_type oldest_read;

   int fail_count;
   int gets_seen;
   int hits_seen;
   int puts_sent;
   int capacity_writes;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;

   logic [KW-1:0] key_pool[KEY_POOL];

   cache_row_type directed_plan[29] = '{
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0,         32'd1,         1'b0, 1'b0, 32'h0},
      // shrinking below the count evicts only on the next insertion
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0007, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0009, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0,         32'd0,         1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0009, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0,         32'd31,        1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0002, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0003, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0,         32'd2,         1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_PUT, 32'h0000_0004, 32'hC3C3_3C3C, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD,     lkvc_pkg::OP_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAPACITY, lkvc_pkg::OP_GET, 32'h0,         32'd16,        1'b0, 1'b0, 32'h0}
   };

   function automatic int unsigned effective_capacity();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
   endfunction

   // Make slot s most recent; valid slots newer than it age by one.
   function automatic void promote(input int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
   endfunction

   // Apply one word to the shadow cache; return 1 when it produces a read result.
   function automatic bit cache_access(input lkvc_pkg::lkvc_op_type op,
                                       input logic [KW-1:0] key,
                                       input logic [VW-1:0] value,
                                       output lkvc_pkg::lkvc_result_type res);
      int s;
      s = -1;
      res = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (s < 0 && slot_used[i] && slot_key[i] == key) s = i;
      if (op == lkvc_pkg::OP_GET) begin
         if (s >= 0) begin
            promote(s);
            res.hit = 1'b1;
            res.read_value = slot_val[s];
         end
         return 1'b1;
      end
      if (s >= 0) begin
         promote(s);
      end else if (used_count >= effective_capacity()) begin
         // reuse the least recent slot
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && (s < 0 || slot_age[i] > slot_age[s])) s = i;
         promote(s);
         slot_key[s] = key;
      end else begin
         for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && !slot_used[i]) s = i;
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i]) slot_age[i]++;
         slot_age[s] = 0;
         slot_used[s] = 1'b1;
         used_count++;
         slot_key[s] = key;
      end
      slot_val[s] = value;
      return 1'b0;
   endfunction

   task automatic issue_word(input cache_row_type w);
      lkvc_pkg::lkvc_result_type predicted;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= w.op;
      req_if.key   <= w.key;
      req_if.value <= w.value;
      do @(posedge clock); while (!req_if.ready);
      if (w.op == lkvc_pkg::OP_PUT) puts_sent++;
      if (cache_access(w.op, w.key, w.value, predicted)) begin
         if (w.typed) begin
            predicted.hit = w.exp_hit;
            predicted.read_value = w.exp_value;
         end
         pending_reads.push_back(predicted);
      end
   endtask

   // Hold off until every read is back and the pipeline has emptied.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CPW-1:0] cap);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cap_reg = cap;
      capacity_writes++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_reads.size() == 0) begin
            $error("read result with nothing outstanding: hit=%0d read_value=%h",
                   rsp_if.hit, rsp_if.read_value);
            fail_count++;
         end else begin
            oldest_read = pending_reads.pop_front();
            if (rsp_if.hit !== oldest_read.hit) begin
               $error("hit: expected %0d, got %0d", oldest_read.hit, rsp_if.hit);
               fail_count++;
            end
            if (rsp_if.read_value !== oldest_read.read_value) begin
               $error("read_value: expected %h, got %h", oldest_read.read_value,
                      rsp_if.read_value);
               fail_count++;
            end
            gets_seen++;
            if (oldest_read.hit) hits_seen++;
         end
      end
   end

   initial begin
      cache_row_type w;
      logic [CPW-1:0] seg_caps[SEGMENTS];

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.op        = lkvc_pkg::OP_GET;
      req_if.key       = '0;
      req_if.value     = '0;
      rsp_if.ready     = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      fail_count       = 0;
      gets_seen        = 0;
      hits_seen        = 0;
      puts_sent        = 0;
      capacity_writes  = 0;
      cycle_count      = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      cap_reg          = lkvc_pkg::CAPACITY_RESET;
      used_count       = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key[i]  = '0;
         slot_val[i]  = '0;
         slot_used[i] = 1'b0;
         slot_age[i]  = 0;
      end
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
      seg_caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd17, 5'd8, 5'd0};
      seg_caps[SEGMENTS-1] = $urandom_range(0, 31);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_CAPACITY)
            write_capacity(directed_plan[r].value[CPW-1:0]);
         else
            issue_word(directed_plan[r]);
      end

      w.kind = ROW_WORD;
      w.typed = 1'b0;
      w.exp_hit = 1'b0;
      w.exp_value = '0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         write_capacity(seg_caps[seg]);
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         for (int n = 0; n < SEG_WORDS; n++) begin
            w.op = ($urandom_range(0, 99) < 55) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_PUT;
            // mostly a pool a little larger than the capacity, so hits and evictions mix
            if ($urandom_range(0, 99) < 10)
               w.key = $urandom();
            else
               w.key = key_pool[$urandom_range(0, effective_capacity() + 3)];
            w.value = $urandom();
            issue_word(w);
         end
      end

      drain();
      $display("Checked %0d gets (%0d hits) against %0d puts over %0d capacity writes,",
               gets_seen, hits_seen, puts_sent, capacity_writes);
      $display("with sender gaps and receiver stalls mixed in four idle patterns.");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
